/* design/dbcs_pkg.sv */
// Shared types and constants for the double-byte Chinese likelihood scorer.
// No dependencies; every other file in the design refers to this package.
package dbcs_pkg;

  // Queue between the byte classifier and the scoring back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Quotient of chinese*2000/(chinese+other) is always below 2000.
  localparam int QUO_W   = 11;
  localparam int SCORE_W = 11;
  localparam int OUT_W   = 32;
  localparam int STEP_W  = $clog2(QUO_W);

  localparam logic [QUO_W:0] SCORE_OFFSET = 12'd1000;

  // Evidence weights.
  localparam int WEIGHT_W = 4;
  localparam logic [WEIGHT_W-1:0] WEIGHT_NONE  = 4'd0;
  localparam logic [WEIGHT_W-1:0] WEIGHT_LIGHT = 4'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_HEAVY = 4'd10;

  // Encoding mode values.
  localparam logic MODE_BIG5 = 1'b0;
  localparam logic MODE_GBK  = 1'b1;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

/* design/dbcs_queue.sv */
// Two-entry first-in first-out queue carrying tally snapshots from the
// classifier to the scoring back end. Depends on dbcs_pkg.
module dbcs_queue #(
  parameter int W = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [W-1:0]     push_data_i,
  input  logic             pop_i,
  output logic [W-1:0]     pop_data_o,
  output dbcs_pkg::q_stat_t stat_o
);

  logic [W-1:0]                    entry_q [dbcs_pkg::QUEUE_DEPTH];
  logic [dbcs_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [dbcs_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [dbcs_pkg::QCNT_W-1:0]     count_q, count_d;
  logic                            do_push, do_pop;

  localparam logic [dbcs_pkg::QPTR_W-1:0] LAST_PTR =
    dbcs_pkg::QPTR_W'(dbcs_pkg::QUEUE_DEPTH - 1);
  localparam logic [dbcs_pkg::QCNT_W-1:0] FULL_CNT =
    dbcs_pkg::QCNT_W'(dbcs_pkg::QUEUE_DEPTH);

  assign stat_o.full  = (count_q == FULL_CNT);
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* design/dbcs_front.sv */
// Byte classifier: tracks lead/trail phase, applies the Big5 or GBK range
// rules and keeps the saturating tallies. Depends on dbcs_pkg.
module dbcs_front #(
  parameter int CW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            mode_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            last_in_buffer_i,
  input  logic            restart_i,
  input  logic            q_full_i,
  output logic            push_o,
  output logic [2*CW-1:0] push_data_o
);

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_TRAIL = 2'd1;
  localparam logic [1:0] PH_SKIP  = 2'd2;

  logic [1:0]    phase_q, phase_d;
  logic [7:0]    held_q, held_d;
  logic [CW-1:0] chinese_q, chinese_d;
  logic [CW-1:0] other_q, other_d;
  logic [CW-1:0] chinese_base, other_base;
  logic [dbcs_pkg::WEIGHT_W-1:0] inc_chinese, inc_other;
  logic          accept;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] v,
                                            input logic [dbcs_pkg::WEIGHT_W-1:0] k);
    logic [CW:0] sum;
    sum = {1'b0, v} + (CW+1)'(k);
    return sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
  endfunction

  function automatic logic lead_is_bad(input logic mode, input logic [7:0] b);
    if (mode == dbcs_pkg::MODE_GBK) begin
      return (b == 8'h80) || (b == 8'hFF);
    end
    return (b <= 8'hA0) || (b >= 8'hFA);
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    chinese_base = restart_i ? CW'(1) : chinese_q;
    other_base   = restart_i ? CW'(1) : other_q;
    phase_d      = phase_q;
    held_d       = held_q;
    inc_chinese  = dbcs_pkg::WEIGHT_NONE;
    inc_other    = dbcs_pkg::WEIGHT_NONE;

    case (phase_q)
      PH_TRAIL: begin
        phase_d = PH_LEAD;
        if (mode_i == dbcs_pkg::MODE_GBK) begin
          if (data_byte_i < 8'h40 || data_byte_i == 8'h7F || data_byte_i == 8'hFF) begin
            inc_other = dbcs_pkg::WEIGHT_HEAVY;
          end else if ((held_q inside {[8'hAA:8'hAF], [8'hF8:8'hFE]} &&
                        data_byte_i >= 8'hA1) ||
                       (held_q inside {[8'hA1:8'hA7]} && data_byte_i <= 8'hA0)) begin
            inc_other = dbcs_pkg::WEIGHT_LIGHT;
          end else begin
            inc_chinese = dbcs_pkg::WEIGHT_LIGHT;
          end
        end else begin
          if (data_byte_i < 8'h40) begin
            inc_other = dbcs_pkg::WEIGHT_HEAVY;
          end else if (held_q inside {[8'hC6:8'hC8]} && data_byte_i >= 8'hA1) begin
            inc_other = dbcs_pkg::WEIGHT_LIGHT;
          end else begin
            inc_chinese = dbcs_pkg::WEIGHT_LIGHT;
          end
        end
      end
      PH_SKIP: begin
        phase_d = PH_LEAD;
      end
      default: begin
        // Expecting a lead byte; the spare phase code behaves the same.
        if (data_byte_i[7]) begin
          if (lead_is_bad(mode_i, data_byte_i)) begin
            inc_other = (mode_i == dbcs_pkg::MODE_GBK) ? dbcs_pkg::WEIGHT_HEAVY
                                                       : dbcs_pkg::WEIGHT_LIGHT;
            phase_d   = PH_SKIP;
          end else begin
            held_d  = data_byte_i;
            phase_d = PH_TRAIL;
          end
        end else begin
          phase_d = PH_LEAD;
        end
      end
    endcase

    if (last_in_buffer_i) begin
      // A lead byte cut off by the buffer end counts heavily against Chinese.
      if (phase_d == PH_TRAIL) begin
        inc_other = dbcs_pkg::WEIGHT_HEAVY;
      end
      phase_d = PH_LEAD;
    end

    chinese_d = sat_add(chinese_base, inc_chinese);
    other_d   = sat_add(other_base, inc_other);
  end

  assign push_o      = accept && last_in_buffer_i;
  assign push_data_o = {chinese_d, other_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEAD;
      held_q    <= '0;
      chinese_q <= CW'(1);
      other_q   <= CW'(1);
    end else if (accept) begin
      phase_q   <= phase_d;
      held_q    <= held_d;
      chinese_q <= chinese_d;
      other_q   <= other_d;
    end
  end

endmodule

/* design/dbcs_back.sv */
// Scoring back end: takes a tally snapshot, forms chinese*2000 and the sum,
// runs an 11-step restoring divider and holds the result. Depends on dbcs_pkg.
module dbcs_back #(
  parameter int CW = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  logic [2*CW-1:0]             q_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [dbcs_pkg::SCORE_W-1:0] score_o,
  output logic [dbcs_pkg::OUT_W-1:0]  chinese_count_o,
  output logic [dbcs_pkg::OUT_W-1:0]  other_count_o
);

  localparam int NW = CW + dbcs_pkg::QUO_W;
  localparam logic [dbcs_pkg::STEP_W-1:0] LAST_STEP = dbcs_pkg::STEP_W'(dbcs_pkg::QUO_W - 1);

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_LOAD = 2'd1;
  localparam logic [1:0] BK_DIV  = 2'd2;
  localparam logic [1:0] BK_DONE = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic [CW-1:0]                  chinese_q, other_q;
  logic [NW-1:0]                  rem_q, dsh_q;
  logic [dbcs_pkg::QUO_W-1:0]     quo_q;
  logic [dbcs_pkg::STEP_W-1:0]    step_q;
  logic [NW:0]                    diff;
  logic [NW-1:0]                  num;
  logic [CW:0]                    den;
  logic [dbcs_pkg::QUO_W:0]       score_wide;
  logic                           out_valid_q;
  logic                           out_free;
  logic                           load_out;

  // 2000 = 2048 - 32 - 16, so the product is three shifted terms.
  assign num  = (NW'(chinese_q) << 11) - (NW'(chinese_q) << 5) - (NW'(chinese_q) << 4);
  assign den  = {1'b0, chinese_q} + {1'b0, other_q};
  assign diff = {1'b0, rem_q} - {1'b0, dsh_q};

  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == BK_DONE) && out_free;
  assign pop_o    = (state_q == BK_IDLE) && !q_empty_i;

  assign score_wide  = {1'b0, quo_q} - dbcs_pkg::SCORE_OFFSET;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!q_empty_i) state_d = BK_LOAD;
      BK_LOAD: state_d = BK_DIV;
      BK_DIV:  if (step_q == LAST_STEP) state_d = BK_DONE;
      BK_DONE: if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == BK_DIV) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      chinese_q <= q_data_i[2*CW-1:CW];
      other_q   <= q_data_i[CW-1:0];
    end
    if (state_q == BK_LOAD) begin
      rem_q <= num;
      dsh_q <= NW'(den) << (dbcs_pkg::QUO_W - 1);
      quo_q <= '0;
    end else if (state_q == BK_DIV) begin
      if (!diff[NW]) begin
        rem_q <= diff[NW-1:0];
        quo_q <= {quo_q[dbcs_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[dbcs_pkg::QUO_W-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
    if (load_out) begin
      score_o         <= $signed(score_wide[dbcs_pkg::SCORE_W-1:0]);
      chinese_count_o <= dbcs_pkg::OUT_W'(chinese_q);
      other_count_o   <= dbcs_pkg::OUT_W'(other_q);
    end
  end

endmodule

/* design/dbcs_chinese_likelihood_scorer.sv */
// Top level of the double-byte Chinese likelihood scorer.
// Depends on dbcs_pkg, dbcs_front, dbcs_queue and dbcs_back.

// The block reads a byte stream split into buffers and scores how likely the
// text is Chinese under Big5 (encoding mode 0) or GBK (mode 1) byte rules. The
// front end takes one byte per cycle, tracks lead and trail bytes and updates
// two saturating tallies that start at one; a restart flag sets both back to
// one before its byte is counted. Only the byte that carries last_in_buffer
// produces a result: score = chinese*2000/(chinese+other) - 1000, together
// with the low 32 bits of both tallies. Each result passes through the back
// end in order: the snapshot is taken from the queue, the operands are formed,
// its restoring divider produces one quotient bit per cycle, and the result
// is handed over to the output register. A
// two-entry queue holds snapshots taken at buffer ends, so the input keeps
// moving at one byte per cycle unless buffer ends arrive faster than the back
// end drains them, in which case the input is stalled while the queue is
// full. A finished result waits in its output register without holding up
// either the divider's next snapshot or the byte stream. The encoding mode
// register should be written only while no transfer is in flight.
module dbcs_chinese_likelihood_scorer #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_in_buffer_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [10:0] score_o,
  output logic [31:0] chinese_count_o,
  output logic [31:0] other_count_o
);

  logic                       mode_q;
  logic                       q_push, q_pop;
  logic [2*COUNT_WIDTH-1:0]   q_push_data, q_pop_data;
  dbcs_pkg::q_stat_t          q_stat;

  // Encoding mode register: Big5 after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dbcs_pkg::MODE_BIG5;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Front end: classification and tallies, one byte per transfer.
  dbcs_front #(
    .CW (COUNT_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (mode_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .last_in_buffer_i (last_in_buffer_i),
    .restart_i        (restart_i),
    .q_full_i         (q_stat.full),
    .push_o           (q_push),
    .push_data_o      (q_push_data)
  );

  // Snapshot queue: decouples the byte stream from the divider.
  dbcs_queue #(
    .W (2 * COUNT_WIDTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .stat_o      (q_stat)
  );

  // Back end: product, sum, division and the output register.
  dbcs_back #(
    .CW (COUNT_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_stat.empty),
    .q_data_i        (q_pop_data),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .score_o         (score_o),
    .chinese_count_o (chinese_count_o),
    .other_count_o   (other_count_o)
  );

  // A snapshot must never be pushed into a full queue, or a result is lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("snapshot pushed into a full queue");

  // The fill count never passes the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= dbcs_pkg::QCNT_W'(dbcs_pkg::QUEUE_DEPTH))
    else $error("queue fill count out of range");

  // Any delivered score lies within the criterion's range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (score_o >= -11'sd1000 && score_o <= 11'sd999))
    else $error("score out of range");

endmodule

/* bench/testbench.sv */
// Self-checking bench for dbcs_chinese_likelihood_scorer, which it instantiates as dut.
// Depends on dbcs_pkg and the design files; it needs nothing else to run.
// Covers directed byte rules in both encodings, random buffers and back-pressure.
module testbench;

  // The tallies are built 16 bits wide.
  localparam int          TALLY_W   = 16;
  localparam longint unsigned TALLY_MAX = (64'd1 << TALLY_W) - 64'd1;
  localparam int          LIMIT     = 400000;
  localparam int          SETTLE    = 32;
  localparam int          HOLD_AT   = 20;
  localparam int          HOLD_LEN  = 300;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_TRAIL,
    PH_SKIP
  } byte_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       restart;
  } text_byte_t;

  typedef struct packed {
    logic signed [dbcs_pkg::SCORE_W-1:0] score;
    logic [dbcs_pkg::OUT_W-1:0]          chinese;
    logic [dbcs_pkg::OUT_W-1:0]          other;
  } score_rec_t;

  logic                                clk_i            = 1'b0;
  logic                                rst_ni           = 1'b0;
  logic                                cfg_we_i         = 1'b0;
  logic                                cfg_data_i       = 1'b0;
  logic                                in_valid_i       = 1'b0;
  logic                                in_stall_o;
  logic [7:0]                          data_byte_i      = 8'h00;
  logic                                last_in_buffer_i = 1'b0;
  logic                                restart_i        = 1'b0;
  logic                                out_valid_o;
  logic                                out_stall_i      = 1'b0;
  logic signed [dbcs_pkg::SCORE_W-1:0] score_o;
  logic [dbcs_pkg::OUT_W-1:0]          chinese_count_o;
  logic [dbcs_pkg::OUT_W-1:0]          other_count_o;

  // Bytes waiting to be offered, and scores that the block still owes us.
  text_byte_t byte_q[$];
  score_rec_t score_q[$];

  // Shadow copy of the block's state, advanced on every accepted byte.
  logic            encoding_q = dbcs_pkg::MODE_BIG5;
  byte_phase_e     phase_q    = PH_LEAD;
  logic [7:0]      held_q     = 8'h00;
  longint unsigned chin_q     = 64'd1;
  longint unsigned oth_q      = 64'd1;

  // The encoding that the stimulus generator is currently writing for.
  logic gen_mode   = dbcs_pkg::MODE_BIG5;
  // While calm is set neither side idles.
  logic calm       = 1'b0;
  int   items_made = 0;
  int   bytes_taken = 0;
  int   scores_seen = 0;
  int   mismatches  = 0;
  int   cycles      = 0;
  int   hold_left   = 0;
  logic hold_done   = 1'b0;

  dbcs_chinese_likelihood_scorer #(
    .COUNT_WIDTH(TALLY_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .last_in_buffer_i(last_in_buffer_i),
    .restart_i       (restart_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .score_o         (score_o),
    .chinese_count_o (chinese_count_o),
    .other_count_o   (other_count_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic longint unsigned sat_add(longint unsigned v, longint unsigned k);
    if (v > TALLY_MAX - k) return TALLY_MAX;
    return v + k;
  endfunction

  function automatic logic lead_is_bad(logic [7:0] b);
    if (encoding_q == dbcs_pkg::MODE_GBK) return (b == 8'h80) || (b == 8'hFF);
    return (b <= 8'hA0) || (b >= 8'hFA);
  endfunction

  // Classifies a lead and trail pair under the encoding in force right now, which is
  // the one that matters when a mode change falls between the two bytes.
  task automatic classify_pair(logic [7:0] lead, logic [7:0] trail);
    if (encoding_q == dbcs_pkg::MODE_GBK) begin
      if (trail < 8'h40 || trail == 8'h7F || trail == 8'hFF) begin
        oth_q = sat_add(oth_q, 64'(dbcs_pkg::WEIGHT_HEAVY));
      end else if ((lead >= 8'hAA && lead <= 8'hAF && trail >= 8'hA1) ||
                   (lead >= 8'hF8 && lead <= 8'hFE && trail >= 8'hA1) ||
                   (lead >= 8'hA1 && lead <= 8'hA7 && trail <= 8'hA0)) begin
        oth_q = sat_add(oth_q, 64'(dbcs_pkg::WEIGHT_LIGHT));
      end else begin
        chin_q = sat_add(chin_q, 64'd1);
      end
    end else begin
      if (trail < 8'h40) begin
        oth_q = sat_add(oth_q, 64'(dbcs_pkg::WEIGHT_HEAVY));
      end else if (lead >= 8'hC6 && lead <= 8'hC8 && trail >= 8'hA1) begin
        oth_q = sat_add(oth_q, 64'(dbcs_pkg::WEIGHT_LIGHT));
      end else begin
        chin_q = sat_add(chin_q, 64'd1);
      end
    end
  endtask

  // Advances the shadow state by one accepted byte and, at a buffer end, queues the
  // score that the block has to report for it.
  task automatic tally_byte(text_byte_t it);
    longint unsigned quo;
    score_rec_t      rec;
    if (it.restart) begin
      chin_q = 64'd1;
      oth_q  = 64'd1;
    end
    case (phase_q)
      PH_TRAIL: begin
        classify_pair(held_q, it.data);
        phase_q = PH_LEAD;
      end
      PH_SKIP: begin
        phase_q = PH_LEAD;
      end
      default: begin
        if (it.data > 8'h7F) begin
          if (lead_is_bad(it.data)) begin
            oth_q = sat_add(oth_q, (encoding_q == dbcs_pkg::MODE_GBK) ?
                                   64'(dbcs_pkg::WEIGHT_HEAVY) :
                                   64'(dbcs_pkg::WEIGHT_LIGHT));
            phase_q = PH_SKIP;
          end else begin
            held_q  = it.data;
            phase_q = PH_TRAIL;
          end
        end else begin
          phase_q = PH_LEAD;
        end
      end
    endcase
    if (it.last) begin
      // A lead left hanging at the end of a buffer counts heavily against Chinese;
      // a pending skip is simply dropped.
      if (phase_q == PH_TRAIL) oth_q = sat_add(oth_q, 64'(dbcs_pkg::WEIGHT_HEAVY));
      phase_q     = PH_LEAD;
      quo         = (chin_q * 64'd2000) / (chin_q + oth_q);
      rec.score   = dbcs_pkg::SCORE_W'(quo - 64'd1000);
      rec.chinese = dbcs_pkg::OUT_W'(chin_q);
      rec.other   = dbcs_pkg::OUT_W'(oth_q);
      score_q.push_back(rec);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the bytes of byte_q in order, idling at random between
  // transfers. A byte that is stalled stays on the port unchanged.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive
    logic moved;
    if (rst_ni) begin
      moved = in_valid_i && !in_stall_o;
      if (moved) begin
        tally_byte(byte_q.pop_front());
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid_i || moved) begin
        if (byte_q.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
          in_valid_i       <= 1'b1;
          data_byte_i      <= byte_q[0].data;
          last_in_buffer_i <= byte_q[0].last;
          restart_i        <= byte_q[0].restart;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall. Once a score count has been reached the receiver holds off for
  // a long stretch, so that the snapshot queue fills and the input is stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (!hold_done && scores_seen >= HOLD_AT) begin
        out_stall_i <= 1'b1;
        hold_left   <= HOLD_LEN;
        hold_done   <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 23);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every score transfer is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    score_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      scores_seen <= scores_seen + 1;
      if (score_q.size() == 0) begin
        $error("unexpected score transfer: score %0d chinese %0d other %0d",
               score_o, chinese_count_o, other_count_o);
        mismatches++;
      end else begin
        want = score_q.pop_front();
        if (score_o !== want.score) begin
          $error("score: expected %0d, got %0d", want.score, score_o);
          mismatches++;
        end
        if (chinese_count_o !== want.chinese) begin
          $error("chinese_count: expected %0d, got %0d", want.chinese, chinese_count_o);
          mismatches++;
        end
        if (other_count_o !== want.other) begin
          $error("other_count: expected %0d, got %0d", want.other, other_count_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d scores outstanding", cycles, score_q.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic put(logic [7:0] d, logic l, logic r);
    text_byte_t it;
    it.data    = d;
    it.last    = l;
    it.restart = r;
    byte_q.push_back(it);
    items_made++;
  endtask

  // Waits until every byte has been transferred and every score has come back, then
  // lets the back end settle so that nothing is in flight when the mode is written.
  task automatic drain();
    while (byte_q.size() != 0 || score_q.size() != 0 || in_valid_i) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_encoding(logic m);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    encoding_q = m;
    gen_mode   = m;
  endtask

  // Valid lead bytes, weighted towards the boundaries of the special ranges.
  function automatic logic [7:0] pick_lead();
    if (gen_mode == dbcs_pkg::MODE_GBK) begin
      case ($urandom_range(5))
        0:       return 8'($urandom_range(8'hAF, 8'hA9));
        1:       return 8'($urandom_range(8'hFE, 8'hF7));
        2:       return 8'($urandom_range(8'hA8, 8'hA0));
        3:       return ($urandom_range(1) == 0) ? 8'h81 : 8'hFE;
        default: return 8'($urandom_range(8'hFE, 8'h81));
      endcase
    end else begin
      case ($urandom_range(4))
        0:       return 8'($urandom_range(8'hC9, 8'hC5));
        1:       return ($urandom_range(1) == 0) ? 8'hA1 : 8'hF9;
        default: return 8'($urandom_range(8'hF9, 8'hA1));
      endcase
    end
  endfunction

  function automatic logic [7:0] pick_bad_lead();
    if (gen_mode == dbcs_pkg::MODE_GBK) return ($urandom_range(1) == 0) ? 8'h80 : 8'hFF;
    if ($urandom_range(1) == 0) return 8'($urandom_range(8'hA0, 8'h80));
    return 8'($urandom_range(8'hFF, 8'hFA));
  endfunction

  // Trail bytes, with the range edges of both encodings picked often.
  function automatic logic [7:0] pick_trail();
    case ($urandom_range(15))
      0:       return 8'h3F;
      1:       return 8'h40;
      2:       return 8'h7E;
      3:       return 8'h7F;
      4:       return 8'h80;
      5:       return 8'hA0;
      6:       return 8'hA1;
      7:       return 8'hFE;
      8:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic emit(logic [7:0] d, inout int n, input int len, input logic rs);
    put(d, n == len - 1, (n == 0) ? rs : ($urandom_range(99) == 0));
    n++;
  endtask

  // One buffer of len bytes. Most buffers are well-formed text (pairs, ASCII, bad
  // leads with their skipped byte); one in ten is raw noise.
  task automatic add_buffer(int len);
    int   n;
    int   pick;
    logic rs;
    logic noise;
    n     = 0;
    rs    = ($urandom_range(19) == 0);
    noise = ($urandom_range(9) == 0);
    while (n < len) begin
      pick = noise ? 99 : $urandom_range(99);
      if (pick < 55) begin
        emit(pick_lead(), n, len, rs);
        if (n < len) emit(pick_trail(), n, len, rs);
      end else if (pick < 75) begin
        emit(8'($urandom_range(8'h7F)), n, len, rs);
      end else if (pick < 87) begin
        emit(pick_bad_lead(), n, len, rs);
        if (n < len) emit(8'($urandom), n, len, rs);
      end else begin
        emit(8'($urandom), n, len, rs);
      end
    end
  endtask

  // Mostly short buffers, so that buffer ends crowd the back end; a few long ones.
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 15) return $urandom_range(2, 1);
    if (r < 90) return $urandom_range(16, 3);
    return $urandom_range(60, 17);
  endfunction

  initial begin : stimulus
    int target;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_encoding(dbcs_pkg::MODE_BIG5);

    // Big5 rules, one of each case. A buffer of ASCII alone scores zero.
    put(8'h00, 1'b1, 1'b1);
    put(8'hA4, 1'b0, 1'b0); put(8'h40, 1'b0, 1'b0);  // Chinese pair
    put(8'hC6, 1'b0, 1'b0); put(8'hA1, 1'b0, 1'b0);  // light weight, reserved lead
    put(8'hC8, 1'b0, 1'b0); put(8'hFF, 1'b0, 1'b0);
    put(8'hF9, 1'b0, 1'b0); put(8'h3F, 1'b0, 1'b0);  // trail below 0x40
    put(8'hA0, 1'b0, 1'b0); put(8'hA4, 1'b0, 1'b0);  // bad lead, a lead value skipped
    put(8'hFA, 1'b0, 1'b0); put(8'h7F, 1'b0, 1'b0);
    put(8'hA1, 1'b1, 1'b0);                          // lead ends the buffer
    put(8'hFF, 1'b1, 1'b0);                          // bad lead ends the buffer
    put(8'hA4, 1'b0, 1'b0); put(8'h41, 1'b1, 1'b1);  // restart on the trail of a pair
    // A lead left pending across the mode change: its trail is judged under GBK.
    put(8'hB0, 1'b0, 1'b0);
    drain();
    set_encoding(dbcs_pkg::MODE_GBK);

    put(8'h7F, 1'b0, 1'b0);
    put(8'h80, 1'b0, 1'b0); put(8'h41, 1'b0, 1'b1);  // restart on a skipped byte
    put(8'hAA, 1'b0, 1'b0); put(8'hA1, 1'b0, 1'b0);
    put(8'hA7, 1'b0, 1'b0); put(8'hA0, 1'b0, 1'b0);
    put(8'h81, 1'b0, 1'b0); put(8'hFF, 1'b0, 1'b0);
    put(8'hFE, 1'b0, 1'b0); put(8'h40, 1'b1, 1'b0);
    put(8'hFF, 1'b1, 1'b0);
    put(8'h81, 1'b1, 1'b1);

    // Random phases in alternating encodings. Each phase ends on a pending lead so
    // that the next one opens with a trail classified under the new mode. The third
    // phase runs with no idling on either side.
    for (int p = 0; p < 4; p++) begin
      drain();
      set_encoding((p % 2 == 0) ? dbcs_pkg::MODE_BIG5 : dbcs_pkg::MODE_GBK);
      calm <= (p == 2);
      target = items_made + 280;
      while (items_made < target) add_buffer(pick_len());
      put(pick_lead(), 1'b0, 1'b0);
    end

    // The lead left pending by the last phase is closed by a trail that ends a buffer.
    put(8'hA1, 1'b1, 1'b0);

    drain();
    calm <= 1'b0;
    repeat (SETTLE) @(posedge clk_i);

    $display("summary: %0d bytes transferred and %0d scores checked under Big5 and GBK,",
             bytes_taken, scores_seen);
    $display("summary: including stalls, mid-pair mode changes and a long receiver hold-off");
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
